### src/crc16_pkg.sv
// Shared types, codes and the CRC-16 byte update for the frame CRC unit.
package crc16_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  // Verdict codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  // Frame modes.
  typedef enum logic {
    MODE_GEN   = 1'b0,
    MODE_CHECK = 1'b1
  } mode_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       mode;
  } in_item_t;

  // Handshake between the input register and the engine.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_hold_t;

  // Fold one byte into the reflected CRC register, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Swap into line order: register low byte is sent first.
  function automatic logic [15:0] sent_order(input logic [15:0] crc);
    return {crc[7:0], crc[15:8]};
  endfunction

endpackage

### src/crc16_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface crc16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       mode;

  modport source (output valid, output data_byte, output last_byte, output mode,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input mode,
                  output ready);
endinterface

interface crc16_out_if;
  logic                valid;
  logic                ready;
  crc16_pkg::kind_t    out_kind;
  logic [7:0]          out_byte;
  crc16_pkg::status_t  status;
  logic [15:0]         crc_value;
  logic                last_result;

  modport source (output valid, output out_kind, output out_byte, output status,
                  output crc_value, output last_result, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input status,
                  input crc_value, input last_result, output ready);
endinterface

### src/crc16_frame_generate_check_unit.sv
// Top level of the Modbus CRC-16 frame generator and checker.
// Usage:
//   in_ch carries one frame byte per item with a last flag; the mode bit
//   (0 generate, 1 check) is sampled on the first byte of each frame.
//   out_ch carries results. In generate mode every byte is echoed and,
//   after the last byte, the two CRC bytes follow (register low byte first).
//   In check mode only the last byte yields a result: a verdict of ok,
//   mismatch or too short, with the CRC computed over the payload.
// Timing:
//   An item passes through an input register and then the result
//   register before its first result is shown.
//   One item per cycle is sustained while out_ch is ready; the last
//   byte of a generate frame holds the result register for its echo and
//   both CRC bytes, and input is held off until the CRC bytes are sent.
// Reset (rst_n low, synchronous) empties both registers and closes any
// open frame. When the receiver stalls the result holds, one more item
// waits in the input register and then in_ch.ready drops.
module crc16_frame_generate_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  crc16_in_if.sink    in_ch,
  crc16_out_if.source out_ch
);

  crc16_pkg::in_hold_t hold;
  logic                take;

  crc16_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .hold  (hold)
  );

  crc16_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .hold   (hold),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

### src/crc16_in_stage.sv
// Input register: holds one accepted byte item until the engine takes it.
module crc16_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  crc16_in_if.sink            in_ch,
  input  logic                take,
  output crc16_pkg::in_hold_t hold
);

  logic                valid_r;
  logic                valid_nxt;
  crc16_pkg::in_item_t item_r;

  // Free when empty or when the held item leaves this cycle
  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
      item_r.mode      <= in_ch.mode;
    end
  end

  assign hold.valid = valid_r;
  assign hold.item  = item_r;

endmodule

### src/crc16_engine.sv
// Frame state, CRC update and result register with the appended CRC byte sequence.
module crc16_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  crc16_pkg::in_hold_t hold,
  output logic                take,
  crc16_out_if.source         out_ch
);

  // Frame state
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        mode_r, mode_nxt;
  logic        in_frame_r, in_frame_nxt;

  // Appended CRC bytes still to send, and the value they come from
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] cv_hold_r, cv_hold_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  crc16_pkg::kind_t    kind_r, kind_nxt;
  logic [7:0]          byte_r, byte_nxt;
  crc16_pkg::status_t  status_r, status_nxt;
  logic [15:0]         crcv_r, crcv_nxt;
  logic                last_r, last_nxt;

  // Per-item working values
  logic        out_free;
  logic        emit_crc;
  logic        fm;
  logic [15:0] crc_base;
  logic [15:0] held_base;
  logic [1:0]  seen_base;
  logic [7:0]  feed_byte;
  logic [15:0] crc_fed;
  logic [15:0] crc_new;
  logic [15:0] cv;
  logic        too_short;

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = hold.valid && (pend_r == 2'd0) && out_free;
  assign emit_crc = (pend_r != 2'd0) && out_free;

  // Work out the frame update for the held item
  always_comb begin
    fm        = in_frame_r ? mode_r : hold.item.mode;
    crc_base  = in_frame_r ? crc_r : crc16_pkg::CRC_INIT;
    held_base = in_frame_r ? held_r : 16'h0000;
    seen_base = in_frame_r ? seen_r : 2'd0;
    too_short = (seen_base == 2'd0);
    feed_byte = (fm == crc16_pkg::MODE_CHECK) ? held_base[15:8] : hold.item.data_byte;
    crc_fed   = crc16_pkg::crc_feed(crc_base, feed_byte);
    if (fm == crc16_pkg::MODE_GEN || seen_base == 2'd2) begin
      crc_new = crc_fed;
    end else begin
      crc_new = crc_base;
    end
    cv = crc16_pkg::sent_order(crc_new);
  end

  // Next state of frame, pending bytes and result register
  always_comb begin
    crc_nxt       = crc_r;
    held_nxt      = held_r;
    seen_nxt      = seen_r;
    mode_nxt      = mode_r;
    in_frame_nxt  = in_frame_r;
    pend_nxt      = pend_r;
    cv_hold_nxt   = cv_hold_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    status_nxt    = status_r;
    crcv_nxt      = crcv_r;
    last_nxt      = last_r;

    // Drop a delivered result
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit_crc) begin
      // Send the appended CRC, first-sent byte first
      out_valid_nxt = 1'b1;
      kind_nxt      = crc16_pkg::KIND_CRC;
      status_nxt    = crc16_pkg::ST_OK;
      crcv_nxt      = cv_hold_r;
      if (pend_r == 2'd2) begin
        byte_nxt = cv_hold_r[15:8];
        last_nxt = 1'b0;
      end else begin
        byte_nxt = cv_hold_r[7:0];
        last_nxt = 1'b1;
      end
      pend_nxt = pend_r - 2'd1;
    end else if (take) begin
      if (fm == crc16_pkg::MODE_GEN) begin
        // Echo the byte; queue the CRC bytes after the last one
        out_valid_nxt = 1'b1;
        kind_nxt      = crc16_pkg::KIND_ECHO;
        byte_nxt      = hold.item.data_byte;
        status_nxt    = crc16_pkg::ST_OK;
        crcv_nxt      = cv;
        last_nxt      = 1'b0;
        if (hold.item.last_byte) begin
          pend_nxt    = 2'd2;
          cv_hold_nxt = cv;
        end
      end else if (hold.item.last_byte) begin
        // Verdict on the trailing pair
        out_valid_nxt = 1'b1;
        kind_nxt      = crc16_pkg::KIND_VERDICT;
        byte_nxt      = 8'h00;
        crcv_nxt      = cv;
        last_nxt      = 1'b1;
        if (too_short) begin
          status_nxt = crc16_pkg::ST_SHORT;
        end else if ({held_base[7:0], hold.item.data_byte} == cv) begin
          status_nxt = crc16_pkg::ST_OK;
        end else begin
          status_nxt = crc16_pkg::ST_MISMATCH;
        end
      end

      // Advance or close the frame
      if (hold.item.last_byte) begin
        crc_nxt      = crc16_pkg::CRC_INIT;
        held_nxt     = 16'h0000;
        seen_nxt     = 2'd0;
        mode_nxt     = crc16_pkg::MODE_GEN;
        in_frame_nxt = 1'b0;
      end else begin
        crc_nxt      = crc_new;
        held_nxt     = {held_base[7:0], hold.item.data_byte};
        seen_nxt     = (seen_base == 2'd2) ? 2'd2 : seen_base + 2'd1;
        mode_nxt     = fm;
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= crc16_pkg::CRC_INIT;
      held_r      <= 16'h0000;
      seen_r      <= 2'd0;
      mode_r      <= crc16_pkg::MODE_GEN;
      in_frame_r  <= 1'b0;
      pend_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      held_r      <= held_nxt;
      seen_r      <= seen_nxt;
      mode_r      <= mode_nxt;
      in_frame_r  <= in_frame_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and saved CRC
  always_ff @(posedge clk) begin
    cv_hold_r <= cv_hold_nxt;
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    status_r  <= status_nxt;
    crcv_r    <= crcv_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_kind    = kind_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.status      = status_r;
  assign out_ch.crc_value   = crcv_r;
  assign out_ch.last_result = last_r;

`ifndef SYNTHESIS
  a_pend_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd0) |-> out_valid_r)
    else $error("CRC bytes pending with empty result register");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("pending CRC count out of range");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hold.item.last_byte) |=> (!in_frame_r && seen_r == 2'd0))
    else $error("frame not closed after last byte");

  a_final_crc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == crc16_pkg::KIND_CRC && last_r) |-> (pend_r == 2'd0))
    else $error("final CRC byte shown with bytes still pending");

  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == crc16_pkg::KIND_VERDICT) |-> (byte_r == 8'h00 && last_r))
    else $error("verdict with non-zero byte or not final");
`endif

endmodule
